// ===== sv/bpa_pkg.sv =====
// Shared constants and types for the buddy page allocator.
package bpa_pkg;

	localparam int DEF_PAGE_COUNT = 4096;
	localparam int DEF_MAX_ORDER  = 10;

	localparam int FUNC_W   = 2;
	localparam int ORDER_W  = 4;
	localparam int STATUS_W = 2;
	localparam int KIND_W   = 2;
	localparam int CFG_AW   = 1;

	typedef logic [KIND_W-1:0] kind_t;

	localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_INIT  = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_OOM     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

	localparam kind_t KIND_RESERVED = 2'd0;
	localparam kind_t KIND_FREE     = 2'd1;
	localparam kind_t KIND_USED     = 2'd2;
	localparam kind_t KIND_TAIL     = 2'd3;

	localparam logic [CFG_AW-1:0] REG_START = 1'b0;
	localparam logic [CFG_AW-1:0] REG_END   = 1'b1;

endpackage

// ===== sv/buddy_page_allocator_core.sv =====
// Binary buddy page allocator: page table and free-list link memories with a sequencer.
//
//   channel   handshake              payload
//   -------   --------------------   ----------------------------------------------
//   request   in_valid / in_ready    func, order, page
//   result    out_valid / out_ready  status, block_page, block_order, free_count,
//                                    used_count
//   config    cfg_we                 cfg_addr, cfg_wdata
//
// One request is worked at a time; in_ready is high only while the sequencer is idle. A query
// reads the page table entry; an alloc pops the smallest non-empty list at or above the requested
// order and splits the block down, while a rejected alloc goes straight to the result; a free merges
// the block with free buddies order by order, and init sweeps every page of the table.
// Reset leaves every free list empty and both totals zero; the page table and link
// memories hold nothing meaningful until an init request sweeps them.
// A finished result waits in the output register; a stalled output holds only the final step.
module buddy_page_allocator_core #(
	parameter int PAGE_COUNT = bpa_pkg::DEF_PAGE_COUNT,
	parameter int MAX_ORDER  = bpa_pkg::DEF_MAX_ORDER
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [bpa_pkg::FUNC_W-1:0]          func,
	input  logic [bpa_pkg::ORDER_W-1:0]         order,
	input  logic [$clog2(PAGE_COUNT)-1:0]       page,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [bpa_pkg::STATUS_W-1:0]        status,
	output logic [$clog2(PAGE_COUNT)-1:0]       block_page,
	output logic [bpa_pkg::ORDER_W-1:0]         block_order,
	output logic [$clog2(PAGE_COUNT+1)-1:0]     free_count,
	output logic [$clog2(PAGE_COUNT+1)-1:0]     used_count,
	input  logic                                cfg_we,
	input  logic [bpa_pkg::CFG_AW-1:0]          cfg_addr,
	input  logic [$clog2(PAGE_COUNT+1)-1:0]     cfg_wdata
);
	import bpa_pkg::*;

	localparam int PW = $clog2(PAGE_COUNT);     // page index
	localparam int CW = $clog2(PAGE_COUNT + 1); // page counts and bounds
	localparam int XW = CW + 1;                 // bound checks without overflow
	localparam int OW = $clog2(MAX_ORDER + 2);  // order, room for MAX_ORDER
	localparam int HW = $clog2(MAX_ORDER + 1);  // free-list head index
	localparam int EW = KIND_W + OW;            // page table entry

	localparam logic [CW-1:0] PC_L = CW'(PAGE_COUNT);
	localparam logic [OW-1:0] MAXO = OW'(MAX_ORDER);
	localparam logic [PW:0]   NIL  = {1'b1, {PW{1'b0}}};

	localparam logic [4:0] S_IDLE     = 5'd0;
	localparam logic [4:0] S_INIT     = 5'd1;
	localparam logic [4:0] S_INIT_LNK = 5'd2;
	localparam logic [4:0] S_POP1     = 5'd3;
	localparam logic [4:0] S_POP2     = 5'd4;
	localparam logic [4:0] S_SPLIT    = 5'd5;
	localparam logic [4:0] S_F_ORD    = 5'd6;
	localparam logic [4:0] S_F_BUD    = 5'd7;
	localparam logic [4:0] S_F_CHK    = 5'd8;
	localparam logic [4:0] S_F_UL1    = 5'd9;
	localparam logic [4:0] S_F_UL2    = 5'd10;
	localparam logic [4:0] S_F_TOP    = 5'd11;
	localparam logic [4:0] S_F_TAIL   = 5'd12;
	localparam logic [4:0] S_F_PUSH1  = 5'd13;
	localparam logic [4:0] S_F_PUSH2  = 5'd14;
	localparam logic [4:0] S_Q        = 5'd15;
	localparam logic [4:0] S_RESP     = 5'd16;

	// control state
	logic [4:0]    state_q;
	logic          out_valid_q;
	logic [PW:0]   head_q [0:MAX_ORDER]; // {nil, page} per order
	logic [CW-1:0] free_q, used_q;
	logic [CW-1:0] start_q, end_q;

	// work registers
	logic [PW-1:0]       p_q;     // init sweep page
	logic [CW-1:0]       nxt_q;   // next block head during init
	logic [PW-1:0]       idx_q;   // block being popped, split or freed
	logic [PW-1:0]       bud_q;
	logic [OW-1:0]       cur_q, req_q;
	logic [PW:0]         lnk_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [PW-1:0]       res_page_q;
	logic [ORDER_W-1:0]  res_order_q;

	logic [STATUS_W-1:0] status_q;
	logic [PW-1:0]       block_page_q;
	logic [ORDER_W-1:0]  block_order_q;
	logic [CW-1:0]       free_count_q, used_count_q;

	// memories
	logic [EW-1:0] pg_mem   [0:PAGE_COUNT-1];
	logic [PW:0]   prev_mem [0:PAGE_COUNT-1];
	logic [PW:0]   next_mem [0:PAGE_COUNT-1];
	logic [EW-1:0] pg_rd;
	logic [PW:0]   prev_rd, next_rd;

	logic          pg_we, pv_we, nx_we;
	logic [PW-1:0] pg_wa, pv_wa, nx_wa, pg_ra, lk_ra;
	logic [EW-1:0] pg_wd;
	logic [PW:0]   pv_wd, nx_wd;

	logic          accept;
	kind_t         rd_kind;
	logic [OW-1:0] rd_ord;
	logic          ord_bad, page_ok;
	logic          fnd_v;
	logic [OW-1:0] fnd_o;
	logic [CW-1:0] e_cl;
	logic          in_reg, is_head, init_last;
	logic [OW-1:0] io;
	logic [CW-1:0] init_size;
	logic [OW-1:0] c;
	logic [PW-1:0] sb, fb, top_pg, tail_pg;
	logic          sb_ok, fb_ok;
	logic [PW:0]   head_cur, head_c, head_io, head_fnd;

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign rd_kind   = pg_rd[EW-1:OW];
	assign rd_ord    = pg_rd[OW-1:0];
	assign ord_bad   = (int'(order) > MAX_ORDER);
	assign page_ok   = (CW'(page) < PC_L);
	assign e_cl      = (end_q > PC_L) ? PC_L : end_q;
	assign in_reg    = (CW'(p_q) >= start_q) && (CW'(p_q) < e_cl);
	assign is_head   = in_reg && (CW'(p_q) == nxt_q);
	assign init_last = (p_q == PW'(PAGE_COUNT - 1));
	assign init_size = CW'(1) << io;
	assign c         = cur_q - OW'(1);
	assign sb        = idx_q ^ (PW'(1) << c);
	assign sb_ok     = (int'(c) < PW) && (CW'(sb) < PC_L);
	assign fb        = idx_q ^ (PW'(1) << cur_q);
	assign fb_ok     = (int'(cur_q) < PW) && (CW'(fb) < PC_L);
	assign top_pg    = (bud_q < idx_q) ? bud_q : idx_q;
	assign tail_pg   = (bud_q < idx_q) ? idx_q : bud_q;
	assign head_cur  = head_q[cur_q[HW-1:0]];
	assign head_c    = head_q[c[HW-1:0]];
	assign head_io   = head_q[io[HW-1:0]];
	assign head_fnd  = head_q[fnd_o[HW-1:0]];

	// smallest non-empty list at or above the requested order
	always_comb begin
		fnd_v = 1'b0;
		fnd_o = '0;
		for (int k = 0; k <= MAX_ORDER; k++) begin
			if (!fnd_v && k >= int'(order) && !head_q[k][PW]) begin
				fnd_v = 1'b1;
				fnd_o = OW'(k);
			end
		end
	end

	// largest aligned block that starts at the sweep page and fits the region
	always_comb begin
		io = '0;
		for (int k = 0; k <= MAX_ORDER; k++) begin
			if (k < CW && (p_q & ((PW'(1) << k) - PW'(1))) == '0 &&
			    (XW'(p_q) + (XW'(1) << k)) <= XW'(e_cl)) begin
				io = OW'(k);
			end
		end
	end

	// memory port steering
	always_comb begin
		pg_ra = page;
		lk_ra = head_fnd[PW-1:0];
		pg_we = 1'b0;
		pg_wa = idx_q;
		pg_wd = {KIND_RESERVED, {OW{1'b0}}};
		pv_we = 1'b0;
		pv_wa = idx_q;
		pv_wd = NIL;
		nx_we = 1'b0;
		nx_wa = idx_q;
		nx_wd = NIL;
		unique case (state_q)
			S_INIT: begin
				pg_we = 1'b1;
				pg_wa = p_q;
				if (is_head) begin
					pg_wd = {KIND_FREE, io};
				end else if (in_reg) begin
					pg_wd = {KIND_TAIL, {OW{1'b0}}};
				end
				pv_we = 1'b1;
				pv_wa = p_q;
				nx_we = 1'b1;
				nx_wa = p_q;
				if (is_head) begin
					nx_wd = head_io;
				end
			end
			S_INIT_LNK: begin
				pv_we = 1'b1;
				pv_wa = lnk_q[PW-1:0];
				pv_wd = {1'b0, p_q};
			end
			S_POP1: begin
				pv_we = 1'b1;
				nx_we = 1'b1;
			end
			S_POP2: begin
				pv_we = !lnk_q[PW];
				pv_wa = lnk_q[PW-1:0];
			end
			S_SPLIT: begin
				if (cur_q > req_q) begin
					if (sb_ok) begin
						pg_we = 1'b1;
						pg_wa = sb;
						pg_wd = {KIND_FREE, c};
						pv_we = 1'b1;
						pv_wa = sb;
						nx_we = 1'b1;
						nx_wa = sb;
						nx_wd = head_c;
					end
				end else begin
					pg_we = 1'b1;
					pg_wd = {KIND_USED, req_q};
				end
			end
			S_F_BUD: pg_ra = fb;
			S_F_CHK: lk_ra = bud_q;
			S_F_UL1: begin
				nx_we = !prev_rd[PW];
				nx_wa = prev_rd[PW-1:0];
				nx_wd = next_rd;
				pv_we = !next_rd[PW];
				pv_wa = next_rd[PW-1:0];
				pv_wd = prev_rd;
			end
			S_F_UL2: begin
				pv_we = 1'b1;
				pv_wa = bud_q;
				nx_we = 1'b1;
				nx_wa = bud_q;
			end
			S_F_TOP: begin
				pg_we = 1'b1;
				pg_wa = top_pg;
				pg_wd = {KIND_FREE, cur_q + OW'(1)};
			end
			S_F_TAIL: begin
				pg_we = 1'b1;
				pg_wa = tail_pg;
				pg_wd = {KIND_TAIL, cur_q};
			end
			S_F_PUSH1: begin
				pg_we = 1'b1;
				pg_wd = {KIND_FREE, cur_q};
				pv_we = 1'b1;
				nx_we = 1'b1;
				nx_wd = head_cur;
			end
			S_F_PUSH2: begin
				pv_we = !lnk_q[PW];
				pv_wa = lnk_q[PW-1:0];
				pv_wd = {1'b0, idx_q};
			end
			default: begin
			end
		endcase
	end

	// page table: kind and order per page
	always_ff @(posedge clk) begin
		if (pg_we) begin
			pg_mem[pg_wa] <= pg_wd;
		end
		pg_rd <= pg_mem[pg_ra];
	end

	// free-list links: prev and next per page, read together
	always_ff @(posedge clk) begin
		if (pv_we) begin
			prev_mem[pv_wa] <= pv_wd;
		end
		if (nx_we) begin
			next_mem[nx_wa] <= nx_wd;
		end
		prev_rd <= prev_mem[lk_ra];
		next_rd <= next_mem[lk_ra];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			end_q   <= PC_L;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_START: start_q <= cfg_wdata;
				REG_END:   end_q   <= cfg_wdata;
			endcase
		end
	end

	// sequencer, list heads and page totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			free_q      <= '0;
			used_q      <= '0;
			for (int k = 0; k <= MAX_ORDER; k++) begin
				head_q[k] <= NIL;
			end
		end else begin
			// drop a taken result unless the next one replaces it this cycle
			if (out_valid_q && out_ready && state_q != S_RESP) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (func)
							FUNC_ALLOC: state_q <= (ord_bad || !fnd_v) ? S_RESP : S_POP1;
							FUNC_FREE:  state_q <= page_ok ? S_F_ORD : S_RESP;
							FUNC_INIT: begin
								for (int k = 0; k <= MAX_ORDER; k++) begin
									head_q[k] <= NIL;
								end
								free_q  <= '0;
								used_q  <= '0;
								state_q <= S_INIT;
							end
							FUNC_QUERY: state_q <= page_ok ? S_Q : S_RESP;
						endcase
					end
				end
				S_INIT: begin
					if (is_head) begin
						head_q[io[HW-1:0]] <= {1'b0, p_q};
						free_q <= free_q + init_size;
					end
					// a block pushed on a non-empty list needs the old head's back link
					if (is_head && !head_io[PW]) begin
						state_q <= S_INIT_LNK;
					end else if (init_last) begin
						state_q <= S_RESP;
					end
				end
				S_INIT_LNK: state_q <= init_last ? S_RESP : S_INIT;
				S_POP1: begin
					head_q[cur_q[HW-1:0]] <= next_rd[PW] ? NIL : next_rd;
					state_q <= S_POP2;
				end
				S_POP2: state_q <= S_SPLIT;
				S_SPLIT: begin
					if (cur_q > req_q) begin
						if (sb_ok) begin
							head_q[c[HW-1:0]] <= {1'b0, sb};
						end
					end else begin
						used_q  <= used_q + (CW'(1) << req_q);
						free_q  <= free_q - (CW'(1) << req_q);
						state_q <= S_RESP;
					end
				end
				S_F_ORD: begin
					used_q  <= used_q - (CW'(1) << rd_ord);
					free_q  <= free_q + (CW'(1) << rd_ord);
					state_q <= S_F_BUD;
				end
				S_F_BUD: state_q <= (cur_q < MAXO && fb_ok) ? S_F_CHK : S_F_PUSH1;
				S_F_CHK: begin
					if (rd_kind == KIND_FREE && rd_ord == cur_q) begin
						state_q <= S_F_UL1;
					end else begin
						state_q <= S_F_PUSH1;
					end
				end
				S_F_UL1: begin
					// buddy without a predecessor is the head of its list
					if (prev_rd[PW] && head_cur == {1'b0, bud_q}) begin
						head_q[cur_q[HW-1:0]] <= next_rd[PW] ? NIL : next_rd;
					end
					state_q <= S_F_UL2;
				end
				S_F_UL2:  state_q <= S_F_TOP;
				S_F_TOP:  state_q <= S_F_TAIL;
				S_F_TAIL: state_q <= S_F_BUD;
				S_F_PUSH1: begin
					head_q[cur_q[HW-1:0]] <= {1'b0, idx_q};
					state_q <= S_F_PUSH2;
				end
				S_F_PUSH2: state_q <= S_RESP;
				S_Q:       state_q <= S_RESP;
				S_RESP: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// work and result registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				res_status_q <= ST_OK;
				res_page_q   <= '0;
				res_order_q  <= '0;
				idx_q        <= (func == FUNC_ALLOC) ? head_fnd[PW-1:0] : page;
				cur_q        <= fnd_o;
				req_q        <= OW'(order);
				p_q          <= '0;
				nxt_q        <= start_q;
				if (func == FUNC_ALLOC) begin
					if (ord_bad) begin
						res_status_q <= ST_INVALID;
					end else if (!fnd_v) begin
						res_status_q <= ST_OOM;
					end
				end
			end
			S_INIT: begin
				if (is_head) begin
					nxt_q <= nxt_q + init_size;
					lnk_q <= head_io;
				end
				if (!(is_head && !head_io[PW]) && !init_last) begin
					p_q <= p_q + PW'(1);
				end
			end
			S_INIT_LNK: begin
				if (!init_last) begin
					p_q <= p_q + PW'(1);
				end
			end
			S_POP1: lnk_q <= next_rd;
			S_SPLIT: begin
				if (cur_q > req_q) begin
					cur_q <= c;
				end else begin
					res_page_q  <= idx_q;
					res_order_q <= ORDER_W'(req_q);
				end
			end
			S_F_ORD: cur_q <= rd_ord;
			S_F_BUD: bud_q <= fb;
			S_F_TAIL: begin
				idx_q <= top_pg;
				cur_q <= cur_q + OW'(1);
			end
			S_F_PUSH1: lnk_q <= head_cur;
			S_Q:       res_order_q <= ORDER_W'(rd_ord);
			S_RESP: begin
				if (!out_valid_q || out_ready) begin
					status_q      <= res_status_q;
					block_page_q  <= res_page_q;
					block_order_q <= res_order_q;
					free_count_q  <= free_q;
					used_count_q  <= used_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign block_page  = block_page_q;
	assign block_order = block_order_q;
	assign free_count  = free_count_q;
	assign used_count  = used_count_q;

endmodule
